@@ rtl/gste_pkg.sv @@
// shared types and constants for the gptp slave timestamp engine
package gste_pkg;

  localparam int IN_DATA_W   = 352;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 144;
  localparam int OUT_USER_W  = 3;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int TIME_W      = 63;
  localparam int IDENT_W     = 64;
  localparam int PORT_W      = 16;
  localparam int SEQ_W       = 16;
  localparam int WIDE_W      = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_IDENT       = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_PORT_NUMBER = 1'd1;

  typedef enum logic [2:0] {
    OP_SYNC            = 3'd0,
    OP_FOLLOWUP        = 3'd1,
    OP_PDELAY_RESP     = 3'd2,
    OP_PDELAY_RESP_FU  = 3'd3,
    OP_ANNOUNCE        = 3'd4,
    OP_PDELAY_REQ_SENT = 3'd5
  } op_t;

  typedef struct packed {
    op_t                     operation;
    logic                    frame_ok;
    logic [SEQ_W-1:0]        seq_num;
    logic [IDENT_W-1:0]      source_ident;
    logic [IDENT_W-1:0]      requesting_ident;
    logic [PORT_W-1:0]       requesting_port_number;
    logic [TIME_W-1:0]       local_time_ns;
    logic [TIME_W-1:0]       message_time_ns;
    logic signed [WIDE_W-1:0] correction_scaled;
  } item_t;

  typedef struct packed {
    logic signed [WIDE_W-1:0] offset_ns;
    logic                     offset_valid;
    logic signed [WIDE_W-1:0] path_delay_ns;
    logic                     path_delay_updated;
    logic [SEQ_W-1:0]         request_sequence_number;
    logic                     master_locked;
  } result_t;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [PORT_W-1:0]  port_number;
  } port_id_t;

endpackage

@@ rtl/gste_delay_calc.sv @@
// smoothed mean path delay update from the four pdelay timestamps
module gste_delay_calc (
  input  logic [gste_pkg::TIME_W-1:0]        t1,
  input  logic [gste_pkg::TIME_W-1:0]        t2,
  input  logic [gste_pkg::TIME_W-1:0]        t3,
  input  logic [gste_pkg::TIME_W-1:0]        t4,
  input  logic signed [gste_pkg::WIDE_W-1:0] old_delay,
  output logic signed [gste_pkg::WIDE_W-1:0] new_delay
);
  import gste_pkg::*;

  logic signed [WIDE_W-1:0] d41;
  logic signed [WIDE_W-1:0] d32;
  logic signed [WIDE_W:0]   diff;
  logic signed [WIDE_W:0]   half;
  logic signed [WIDE_W+3:0] old_x;
  logic signed [WIDE_W+3:0] acc;
  logic signed [WIDE_W+3:0] acc_rnd;
  logic signed [WIDE_W+3:0] acc_div;

  always_comb begin
    // 63-bit times, so the 64-bit differences are exact
    d41  = $signed({1'b0, t4} - {1'b0, t1});
    d32  = $signed({1'b0, t2} - {1'b0, t3}) ;
    diff = {d41[WIDE_W-1], d41} + {d32[WIDE_W-1], d32};
    // halve toward zero
    half = (diff + {{WIDE_W{1'b0}}, diff[WIDE_W]}) >>> 1;
    old_x = {{4{old_delay[WIDE_W-1]}}, old_delay};
    acc   = (old_x <<< 3) - old_x + {{4{half[WIDE_W-1]}}, half[WIDE_W-1:0]};
    // divide by eight toward zero
    acc_rnd = acc + (acc[WIDE_W+3] ? (WIDE_W+4)'(7) : (WIDE_W+4)'(0));
    acc_div = acc_rnd >>> 3;
    new_delay = acc_div[WIDE_W-1:0];
  end

endmodule

@@ rtl/gste_event_core.sv @@
// per-item protocol state: master lock, sync capture, pdelay captures, path delay
module gste_event_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  gste_pkg::item_t     item,
  input  gste_pkg::port_id_t  local_id,
  output gste_pkg::result_t   result
);
  import gste_pkg::*;

  logic                     master_valid_r, master_valid_nxt;
  logic [IDENT_W-1:0]       master_identity_r, master_identity_nxt;
  logic [SEQ_W-1:0]         sync_sequence_r, sync_sequence_nxt;
  logic [TIME_W-1:0]        sync_time_r, sync_time_nxt;
  logic [TIME_W-1:0]        req_send_time_r, req_send_time_nxt;
  logic [TIME_W-1:0]        resp_rx_time_r, resp_rx_time_nxt;
  logic [TIME_W-1:0]        remote_rx_time_r, remote_rx_time_nxt;
  logic signed [WIDE_W-1:0] smoothed_r, smoothed_nxt;
  logic [SEQ_W-1:0]         next_seq_r, next_seq_nxt;
  logic                     sync_seen_r, sync_seen_nxt;
  logic                     request_seen_r, request_seen_nxt;
  logic                     response_seen_r, response_seen_nxt;

  logic                     ours;
  logic signed [WIDE_W-1:0] corr_ns;
  logic signed [WIDE_W-1:0] new_delay;

  gste_delay_calc u_delay (
    .t1        (req_send_time_r),
    .t2        (remote_rx_time_r),
    .t3        (item.message_time_ns),
    .t4        (resp_rx_time_r),
    .old_delay (smoothed_r),
    .new_delay (new_delay)
  );

  always_comb begin
    ours = (item.requesting_ident == local_id.ident) &&
           (item.requesting_port_number == local_id.port_number);
    corr_ns = item.correction_scaled >>> 16;

    master_valid_nxt    = master_valid_r;
    master_identity_nxt = master_identity_r;
    sync_sequence_nxt   = sync_sequence_r;
    sync_time_nxt       = sync_time_r;
    req_send_time_nxt   = req_send_time_r;
    resp_rx_time_nxt    = resp_rx_time_r;
    remote_rx_time_nxt  = remote_rx_time_r;
    smoothed_nxt        = smoothed_r;
    next_seq_nxt        = next_seq_r;
    sync_seen_nxt       = sync_seen_r;
    request_seen_nxt    = request_seen_r;
    response_seen_nxt   = response_seen_r;

    result.offset_ns               = '0;
    result.offset_valid            = 1'b0;
    result.path_delay_updated      = 1'b0;
    result.request_sequence_number = '0;

    // request send stamps are taken whatever the frame check says
    if (item.operation == OP_PDELAY_REQ_SENT) begin
      req_send_time_nxt = item.local_time_ns;
      request_seen_nxt  = 1'b1;
      result.request_sequence_number = next_seq_r;
      next_seq_nxt = next_seq_r + SEQ_W'(1);
    end else if (item.frame_ok) begin
      case (item.operation)
        OP_SYNC: begin
          if (!master_valid_r || item.source_ident == master_identity_r) begin
            sync_sequence_nxt = item.seq_num;
            sync_time_nxt     = item.local_time_ns;
            sync_seen_nxt     = 1'b1;
          end
        end
        OP_FOLLOWUP: begin
          if (sync_seen_r && item.seq_num == sync_sequence_r) begin
            result.offset_ns = $signed({1'b0, sync_time_r}) -
                               ($signed({1'b0, item.message_time_ns}) + corr_ns);
            result.offset_valid = 1'b1;
          end
        end
        OP_PDELAY_RESP: begin
          if (ours) begin
            resp_rx_time_nxt   = item.local_time_ns;
            remote_rx_time_nxt = item.message_time_ns;
            response_seen_nxt  = 1'b1;
          end
        end
        OP_PDELAY_RESP_FU: begin
          if (ours && request_seen_r && response_seen_r) begin
            smoothed_nxt              = new_delay;
            result.path_delay_updated = 1'b1;
            req_send_time_nxt         = '0;
            resp_rx_time_nxt          = '0;
            remote_rx_time_nxt        = '0;
            request_seen_nxt          = 1'b0;
            response_seen_nxt         = 1'b0;
          end
        end
        OP_ANNOUNCE: begin
          if (!master_valid_r) begin
            master_identity_nxt = item.source_ident;
            master_valid_nxt    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    result.path_delay_ns = smoothed_nxt;
    result.master_locked = master_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_valid_r    <= 1'b0;
      master_identity_r <= '0;
      sync_sequence_r   <= '0;
      sync_time_r       <= '0;
      req_send_time_r   <= '0;
      resp_rx_time_r    <= '0;
      remote_rx_time_r  <= '0;
      smoothed_r        <= '0;
      next_seq_r        <= '0;
      sync_seen_r       <= 1'b0;
      request_seen_r    <= 1'b0;
      response_seen_r   <= 1'b0;
    end else if (fire) begin
      master_valid_r    <= master_valid_nxt;
      master_identity_r <= master_identity_nxt;
      sync_sequence_r   <= sync_sequence_nxt;
      sync_time_r       <= sync_time_nxt;
      req_send_time_r   <= req_send_time_nxt;
      resp_rx_time_r    <= resp_rx_time_nxt;
      remote_rx_time_r  <= remote_rx_time_nxt;
      smoothed_r        <= smoothed_nxt;
      next_seq_r        <= next_seq_nxt;
      sync_seen_r       <= sync_seen_nxt;
      request_seen_r    <= request_seen_nxt;
      response_seen_r   <= response_seen_nxt;
    end
  end

  // grandmaster lock never drops once taken
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    master_valid_r |=> master_valid_r)
    else $error("master lock dropped");

  // each request sent bumps the sequence counter by one
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.operation == OP_PDELAY_REQ_SENT |=>
      next_seq_r == $past(next_seq_r) + SEQ_W'(1))
    else $error("request sequence did not advance");

  // a path delay update starts a fresh round
  a_upd_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.path_delay_updated |=>
      !request_seen_r && !response_seen_r && req_send_time_r == '0)
    else $error("pdelay captures not cleared");

  // short frames leave lock and delay untouched
  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.frame_ok && item.operation != OP_PDELAY_REQ_SENT |=>
      $stable(master_valid_r) && $stable(smoothed_r) && $stable(sync_seen_r))
    else $error("short frame changed state");

endmodule

@@ rtl/gptp_slave_timestamp_engine_unit.sv @@
// top level: stream ports, config registers, input and result registers
// The engine takes one parsed gPTP event item per clock cycle while in_tready
// is high and returns one result item for it: the item is held in an input
// register, the protocol state and the path delay average are updated by one
// pass of logic, and the result lands in an output register. in_tready stays
// high while the output register is empty or being taken, so a stalled result
// side holds at most two items before the input side backs up. Configuration
// writes are taken in any cycle and act on items processed after them.
module gptp_slave_timestamp_engine_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // seq_id[15:0] src_clock[79:16] req_clock[143:80] req_port[159:144]
  // local_time[222:160] msg_time[285:223] correction[349:286] zero pad[351:350]
  input  logic [gste_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation[2:0] frame_ok[3]
  input  logic [gste_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // offset_ns[63:0] path_delay_ns[127:64] request_sequence_number[143:128]
  output logic [gste_pkg::OUT_DATA_W-1:0]    out_tdata,
  // offset_valid[0] path_delay_updated[1] master_locked[2]
  output logic [gste_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                               cfg_wen,
  input  logic [gste_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gste_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gste_pkg::*;

  item_t    in_item;
  item_t    item_r;
  logic     in_valid_r;
  logic     out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  port_id_t local_id_r;
  logic     advance;
  logic     fire;
  result_t  res;

  always_comb begin
    in_item.operation              = op_t'(in_tuser[2:0]);
    in_item.frame_ok               = in_tuser[3];
    in_item.seq_num                = in_tdata[15:0];
    in_item.source_ident           = in_tdata[79:16];
    in_item.requesting_ident       = in_tdata[143:80];
    in_item.requesting_port_number = in_tdata[159:144];
    in_item.local_time_ns          = in_tdata[222:160];
    in_item.message_time_ns        = in_tdata[285:223];
    in_item.correction_scaled      = $signed(in_tdata[349:286]);
  end

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_LOCAL_IDENT:       local_id_r.ident       <= cfg_wdata;
        REG_LOCAL_PORT_NUMBER: local_id_r.port_number <= cfg_wdata[PORT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  gste_event_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item_r),
    .local_id (local_id_r),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {res.request_sequence_number, res.path_delay_ns, res.offset_ns};
      out_user_r <= {res.master_locked, res.path_delay_updated, res.offset_valid};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ test/tb.sv @@
// testbench for the gptp slave timestamp engine: directed event table plus random exchanges
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gste_pkg::*;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  localparam logic [IDENT_W-1:0] DIR_CLOCK = 64'h0123_4567_89AB_CDEF;
  localparam logic [PORT_W-1:0] DIR_PORT = 16'h8001;
  localparam logic [IDENT_W-1:0] GM_CLOCK = {IDENT_W{1'b1}};
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    item_t   ev;
    bit      typed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gptp_slave_timestamp_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine state as seen by the predictor
  logic [IDENT_W-1:0] my_ident = '0;
  logic [PORT_W-1:0] my_port = '0;
  logic gm_locked = 1'b0;
  logic [IDENT_W-1:0] gm_id = '0;
  logic [SEQ_W-1:0] sync_seq = '0;
  logic [TIME_W-1:0] t_sync_rx = '0;
  logic [TIME_W-1:0] t_req_tx = '0;
  logic [TIME_W-1:0] t_resp_rx = '0;
  logic [TIME_W-1:0] t_remote_rx = '0;
  logic signed [WIDE_W-1:0] mean_delay = '0;
  logic [SEQ_W-1:0] req_seq_next = '0;
  logic have_sync = 1'b0;
  logic have_req = 1'b0;
  logic have_resp = 1'b0;

  row_t event_q[$];
  result_t result_q[$];
  row_t cur_row;
  result_t pred;
  result_t want;
  int unsigned items_in_flight = 0;
  int unsigned items_queued = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = rand64();
    return v[TIME_W-1:0];
  endfunction

  function automatic port_id_t rand_port();
    port_id_t p;
    p.ident = rand64();
    p.port_number = PORT_W'($urandom);
    return p;
  endfunction

  function automatic item_t event_item(logic [2:0] op, logic ok, logic [SEQ_W-1:0] seq,
                                       logic [IDENT_W-1:0] src, port_id_t req,
                                       logic [TIME_W-1:0] t_local, logic [TIME_W-1:0] t_msg,
                                       logic [WIDE_W-1:0] corr);
    item_t it;
    it.operation = op_t'(op);
    it.frame_ok = ok;
    it.seq_num = seq;
    it.source_ident = src;
    it.requesting_ident = req.ident;
    it.requesting_port_number = req.port_number;
    it.local_time_ns = t_local;
    it.message_time_ns = t_msg;
    it.correction_scaled = corr;
    return it;
  endfunction

  function automatic result_t result_of(logic signed [WIDE_W-1:0] offset, logic ov,
                                        logic signed [WIDE_W-1:0] delay, logic upd,
                                        logic [SEQ_W-1:0] rseq, logic locked);
    result_t r;
    r.offset_ns = offset;
    r.offset_valid = ov;
    r.path_delay_ns = delay;
    r.path_delay_updated = upd;
    r.request_sequence_number = rseq;
    r.master_locked = locked;
    return r;
  endfunction

  task automatic push_row(item_t ev, bit typed = 1'b0, result_t w = '0);
    row_t row;
    row.ev = ev;
    row.typed = typed;
    row.want = w;
    event_q.push_back(row);
    items_in_flight++;
    items_queued++;
  endtask

  // (7 * old + ((t4 - t1) - (t3 - t2)) / 2) / 8, each division truncated toward zero
  function automatic logic signed [WIDE_W-1:0] next_mean_delay(
      logic [TIME_W-1:0] t1, logic [TIME_W-1:0] t2, logic [TIME_W-1:0] t3,
      logic [TIME_W-1:0] t4, logic signed [WIDE_W-1:0] old);
    logic signed [63:0] d41;
    logic signed [63:0] d32;
    logic signed [63:0] half;
    logic signed [127:0] wide;
    d41 = {1'b0, t4} - {1'b0, t1};
    d32 = {1'b0, t3} - {1'b0, t2};
    wide = d41 - d32;
    wide = wide / 2;
    half = wide[63:0];
    wide = old * 7 + half;
    wide = wide / 8;
    return wide[63:0];
  endfunction

  function automatic result_t timestamp_step(item_t it);
    result_t r;
    logic ours;
    logic signed [WIDE_W-1:0] corr_ns;
    r = '0;
    ours = it.requesting_ident == my_ident && it.requesting_port_number == my_port;
    if (it.operation == OP_PDELAY_REQ_SENT) begin
      // request send time is taken whatever the frame check says
      t_req_tx = it.local_time_ns;
      have_req = 1'b1;
      r.request_sequence_number = req_seq_next;
      req_seq_next = req_seq_next + 1'b1;
    end else if (it.frame_ok) begin
      case (it.operation)
        OP_SYNC: begin
          if (!gm_locked || it.source_ident == gm_id) begin
            sync_seq = it.seq_num;
            t_sync_rx = it.local_time_ns;
            have_sync = 1'b1;
          end
        end
        OP_FOLLOWUP: begin
          if (have_sync && it.seq_num == sync_seq) begin
            corr_ns = it.correction_scaled >>> 16;
            r.offset_ns = {1'b0, t_sync_rx} - ({1'b0, it.message_time_ns} + corr_ns);
            r.offset_valid = 1'b1;
          end
        end
        OP_PDELAY_RESP: begin
          if (ours) begin
            t_resp_rx = it.local_time_ns;
            t_remote_rx = it.message_time_ns;
            have_resp = 1'b1;
          end
        end
        OP_PDELAY_RESP_FU: begin
          if (ours && have_req && have_resp) begin
            mean_delay = next_mean_delay(t_req_tx, t_remote_rx, it.message_time_ns,
                                         t_resp_rx, mean_delay);
            r.path_delay_updated = 1'b1;
            t_req_tx = '0;
            t_resp_rx = '0;
            t_remote_rx = '0;
            have_req = 1'b0;
            have_resp = 1'b0;
          end
        end
        OP_ANNOUNCE: begin
          if (!gm_locked) begin
            gm_id = it.source_ident;
            gm_locked = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.path_delay_ns = mean_delay;
    r.master_locked = gm_locked;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_LOCAL_IDENT) my_ident = val;
    else my_port = val[PORT_W-1:0];
  endtask

  task automatic set_port_id(logic [IDENT_W-1:0] id, logic [PORT_W-1:0] port);
    write_reg(REG_LOCAL_IDENT, id);
    write_reg(REG_LOCAL_PORT_NUMBER, {{(CFG_DATA_W-PORT_W){1'b0}}, port});
  endtask

  // wait until every item has come back, then let the pipeline settle
  task automatic drain();
    while (items_in_flight != 0 || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // requester id of a response: mostly this port, sometimes one bit off
  function automatic port_id_t requester();
    port_id_t p;
    p.ident = my_ident;
    p.port_number = my_port;
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) == 0) p.ident[$urandom_range(0, IDENT_W-1)] ^= 1'b1;
      else p.port_number[$urandom_range(0, PORT_W-1)] ^= 1'b1;
    end
    return p;
  endfunction

  function automatic logic frame_good();
    return $urandom_range(0, 15) != 0;
  endfunction

  task automatic queue_random_round();
    logic [TIME_W-1:0] t1, t2, t3, t4;
    logic [IDENT_W-1:0] src;
    logic [SEQ_W-1:0] seq, fu_seq;
    logic [WIDE_W-1:0] corr;
    int unsigned pick, link, turn, n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // peer delay exchange: t1 request out, t2 remote in, t3 remote out, t4 response in
      link = $urandom_range(0, 20000);
      turn = $urandom_range(0, 1000000);
      t1 = rand_time();
      t2 = rand_time();
      t3 = t2 + turn;
      t4 = t1 + 2 * link + turn;
      if ($urandom_range(0, 7) == 0) begin
        t3 = rand_time();
        t4 = rand_time();
      end
      if ($urandom_range(0, 9) != 0)
        push_row(event_item(OP_PDELAY_REQ_SENT, 1'($urandom_range(0, 1)), SEQ_W'($urandom),
                            rand64(), rand_port(), t1, rand_time(), rand64()));
      if ($urandom_range(0, 9) != 0)
        push_row(event_item(OP_PDELAY_RESP, frame_good(), SEQ_W'($urandom), rand64(),
                            requester(), t4, t2, rand64()));
      push_row(event_item(OP_PDELAY_RESP_FU, frame_good(), SEQ_W'($urandom), rand64(),
                          requester(), rand_time(), t3, rand64()));
      if ($urandom_range(0, 15) == 0)
        push_row(event_item(OP_PDELAY_RESP_FU, 1'b1, SEQ_W'($urandom), rand64(), requester(),
                            rand_time(), rand_time(), rand64()));
    end else if (pick < 80) begin
      src = gm_locked ? gm_id : rand64();
      if ($urandom_range(0, 7) == 0) src = rand64();
      seq = SEQ_W'($urandom);
      fu_seq = seq;
      if ($urandom_range(0, 7) == 0) fu_seq = seq ^ SEQ_W'($urandom_range(1, 65535));
      t2 = rand_time();
      t1 = t2 - $urandom_range(0, 2000000);
      corr = 64'($urandom_range(0, 1 << 26));
      if ($urandom_range(0, 1) == 0) corr = -corr;
      if ($urandom_range(0, 7) == 0) corr = rand64();
      if ($urandom_range(0, 7) == 0) t1 = rand_time();
      if ($urandom_range(0, 9) != 0)
        push_row(event_item(OP_SYNC, frame_good(), seq, src, rand_port(), t2, rand_time(),
                            rand64()));
      push_row(event_item(OP_FOLLOWUP, frame_good(), fu_seq, src, rand_port(), rand_time(),
                          t1, corr));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n)
        push_row(event_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            SEQ_W'($urandom), rand64(), rand_port(), rand_time(),
                            rand_time(), rand64()));
    end
  endtask

  // input side: hold an item until taken, predict it at the accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred = timestamp_step(cur_row.ev);
        result_q.push_back(cur_row.typed ? cur_row.want : pred);
        items_in_flight--;
      end
      if (!in_tvalid || in_tready) begin
        if (event_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 34)) begin
          cur_row = event_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, cur_row.ev.correction_scaled, cur_row.ev.message_time_ns,
                       cur_row.ev.local_time_ns, cur_row.ev.requesting_port_number,
                       cur_row.ev.requesting_ident, cur_row.ev.source_ident,
                       cur_row.ev.seq_num};
          in_tuser <= {cur_row.ev.frame_ok, cur_row.ev.operation};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: random back-pressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        note_mismatch("result item with nothing expected");
      end else begin
        want = result_q.pop_front();
        if (out_tdata[63:0] !== want.offset_ns)
          note_mismatch($sformatf("offset_ns got %h want %h", out_tdata[63:0], want.offset_ns));
        if (out_tuser[0] !== want.offset_valid)
          note_mismatch($sformatf("offset_valid got %b want %b", out_tuser[0],
                                  want.offset_valid));
        if (out_tdata[127:64] !== want.path_delay_ns)
          note_mismatch($sformatf("path_delay_ns got %h want %h", out_tdata[127:64],
                                  want.path_delay_ns));
        if (out_tuser[1] !== want.path_delay_updated)
          note_mismatch($sformatf("path_delay_updated got %b want %b", out_tuser[1],
                                  want.path_delay_updated));
        if (out_tdata[143:128] !== want.request_sequence_number)
          note_mismatch($sformatf("request_sequence_number got %h want %h", out_tdata[143:128],
                                  want.request_sequence_number));
        if (out_tuser[2] !== want.master_locked)
          note_mismatch($sformatf("master_locked got %b want %b", out_tuser[2],
                                  want.master_locked));
      end
    end
    out_tready <= no_gaps || $urandom_range(0, 99) >= 34;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_port_id(DIR_CLOCK, DIR_PORT);

    // unused operations after reset
    push_row(event_item(OP_UNUSED_A, 1'b1, '0, '0, '0, '0, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    push_row(event_item(OP_UNUSED_B, 1'b1, '1, '1, '1, T_MAX, T_MAX, '1), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    // follow-up with no sync recorded yet
    push_row(event_item(OP_FOLLOWUP, 1'b1, '0, '0, '0, '0, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    // short frames change nothing
    push_row(event_item(OP_SYNC, 1'b0, 16'd7, 64'd1, '0, 63'd77, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    push_row(event_item(OP_ANNOUNCE, 1'b0, '0, 64'd1, '0, '0, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    // request sent ignores the frame check
    push_row(event_item(OP_PDELAY_REQ_SENT, 1'b0, '0, '0, '0, '0, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    // response follow-up before any response: incomplete round
    push_row(event_item(OP_PDELAY_RESP_FU, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT}, '0, 63'd9,
                        '0), 1'b1, result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    // sync before any lock is taken from anyone
    push_row(event_item(OP_SYNC, 1'b1, 16'd3, 64'hDEAD_BEEF, '0, 63'd1000, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b0));
    push_row(event_item(OP_FOLLOWUP, 1'b1, 16'd3, '0, '0, '0, 63'd400, 64'd100 << 16), 1'b1,
             result_of(500, 1'b1, 0, 1'b0, 0, 1'b0));
    push_row(event_item(OP_ANNOUNCE, 1'b1, '0, GM_CLOCK, '0, '0, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b1));
    push_row(event_item(OP_ANNOUNCE, 1'b1, '0, '0, '0, '0, '0, '0), 1'b1,
             result_of(0, 1'b0, 0, 1'b0, 0, 1'b1));
    // sync from a foreign master, then a follow-up that no longer matches
    push_row(event_item(OP_SYNC, 1'b1, 16'd9, '0, '0, 63'd5, '0, '0));
    push_row(event_item(OP_FOLLOWUP, 1'b1, 16'd9, '0, '0, '0, 63'd1, '0));
    push_row(event_item(OP_SYNC, 1'b1, '1, GM_CLOCK, '0, T_MAX, '0, '0));
    push_row(event_item(OP_FOLLOWUP, 1'b1, '1, GM_CLOCK, '0, '0, '0, 64'h8000_0000_0000_0000));
    push_row(event_item(OP_FOLLOWUP, 1'b1, '1, GM_CLOCK, '0, '0, T_MAX,
                        64'h7FFF_FFFF_FFFF_FFFF));
    push_row(event_item(OP_FOLLOWUP, 1'b0, '1, GM_CLOCK, '0, '0, 63'd3, '0));
    // one clean peer delay round with foreign responses mixed in
    push_row(event_item(OP_PDELAY_REQ_SENT, 1'b1, '0, '0, '0, 63'd1000, '0, '0));
    push_row(event_item(OP_PDELAY_RESP, 1'b1, '0, '0, {DIR_CLOCK ^ 64'd1, DIR_PORT}, 63'd7,
                        63'd7, '0));
    push_row(event_item(OP_PDELAY_RESP, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT ^ 16'h8000}, 63'd7,
                        63'd7, '0));
    push_row(event_item(OP_PDELAY_RESP, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT}, 63'd1300,
                        63'd5000, '0));
    push_row(event_item(OP_PDELAY_RESP_FU, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT ^ 16'd1}, '0,
                        63'd5100, '0));
    push_row(event_item(OP_PDELAY_RESP_FU, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT}, '0, 63'd5100,
                        '0), 1'b1, result_of(0, 1'b0, 12, 1'b1, 0, 1'b1));
    push_row(event_item(OP_PDELAY_RESP_FU, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT}, '0, 63'd5100,
                        '0), 1'b1, result_of(0, 1'b0, 12, 1'b0, 0, 1'b1));
    // extreme times: largest negative round trip
    push_row(event_item(OP_PDELAY_REQ_SENT, 1'b1, '0, '0, '0, T_MAX, '0, '0));
    push_row(event_item(OP_PDELAY_RESP, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT}, '0, '0, '0));
    push_row(event_item(OP_PDELAY_RESP_FU, 1'b1, '0, '0, {DIR_CLOCK, DIR_PORT}, '0, T_MAX, '0));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_port_id('0, '0);
        1: set_port_id('1, '1);
        default: set_port_id(rand64(), PORT_W'($urandom));
      endcase
      no_gaps = (phase == 2);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) queue_random_round();
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gste_pkg.sv
rtl/gste_delay_calc.sv
rtl/gste_event_core.sv
rtl/gptp_slave_timestamp_engine_unit.sv
test/tb.sv
